### rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, constants and the FNV-1a 64 byte fold for the BF16 to F32
// checked converter.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Element counter width; the counter saturates at its all-ones value
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned ExpElemWidth = 32;
  localparam int unsigned CmpWidth     =
      (CountWidth > ExpElemWidth) ? CountWidth : ExpElemWidth;

  localparam int unsigned WordWidth  = 16;
  localparam int unsigned F32Width   = 32;
  localparam int unsigned HashWidth  = 64;
  localparam int unsigned TdataOutW  = 168;

  // Queue between front and back
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrWidth  = $clog2(QDepth);
  localparam int unsigned QCntWidth  = $clog2(QDepth + 1);

  localparam logic [HashWidth-1:0] FnvBasis    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HashWidth-1:0] FnvPrimeLow = 64'h0000_0000_0000_01B3;
  localparam int unsigned          FnvPrimeSh  = 40;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_EXP_SRC_HASH = 2'd0,
    CFG_EXP_OUT_HASH = 2'd1,
    CFG_EXP_ELEMENTS = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_e;

  // One queued item: the word and its end-of-slice mark
  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 last;
  } bfc_item_t;

  // Fold one byte: xor, then multiply by the prime 2^40 + 0x1B3 mod 2^64
  function automatic logic [HashWidth-1:0] fnv_fold(input logic [HashWidth-1:0] h,
                                                    input logic [7:0]           b);
    logic [HashWidth-1:0] x;
    x = h ^ {{(HashWidth-8){1'b0}}, b};
    return (x << FnvPrimeSh) + (x * FnvPrimeLow);
  endfunction

endpackage

### rtl/bfc_front.sv
// ----------------------------------------------------------------------------
// bfc_front
// Input side: accepts stream transfers and holds them in a short queue
// for the hash engine.
// ----------------------------------------------------------------------------
module bfc_front import bfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [WordWidth-1:0] s_axis_tdata_i,   // [15:0] bf16_word
  input  logic                 s_axis_tlast_i,   // is_final
  output logic                 q_valid_o,
  output bfc_item_t            q_item_o,
  input  logic                 q_pop_i
);

  bfc_item_t              mem_q [QDepth];
  logic [QPtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0]   cnt_q, cnt_d;
  logic                   push;
  logic                   pop;

  // Accept while the queue has room
  assign s_axis_tready_o = (cnt_q != QCntWidth'(QDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_valid_o       = (cnt_q != '0);
  assign pop             = q_pop_i && q_valid_o;
  assign q_item_o        = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrWidth'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrWidth'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{word: s_axis_tdata_i, last: s_axis_tlast_i};
    end
  end

endmodule

### rtl/bfc_back.sv
// ----------------------------------------------------------------------------
// bfc_back
// Hash engine: folds one byte per cycle, unless stalled, into the FNV-1a 64
// hashes, keeps the element count and the expected values, drives the result.
// ----------------------------------------------------------------------------
module bfc_back import bfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [HashWidth-1:0]  cfg_data_i,
  input  logic                  q_valid_i,
  input  bfc_item_t             q_item_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [TdataOutW-1:0]  m_axis_tdata_o,  // f32_pattern, source_digest,
                                                 // output_digest, source_ok,
                                                 // output_ok, count_ok, pad
  output logic                  m_axis_tlast_o   // end_of_slice
);

  // Configuration registers
  logic [HashWidth-1:0]    exp_src_q;
  logic [HashWidth-1:0]    exp_out_q;
  logic [ExpElemWidth-1:0] exp_elem_q;

  // Running state
  logic [HashWidth-1:0]  src_acc_q, src_acc_d;
  logic [HashWidth-1:0]  out_acc_q, out_acc_d;
  logic [CountWidth-1:0] tally_q, tally_d;

  // Item in work
  logic                  busy_q, busy_d;
  logic [1:0]            step_q, step_d;
  bfc_item_t             item_q;

  // Result register
  logic                  res_valid_q, res_valid_d;
  logic [WordWidth-1:0]  res_word_q;
  logic                  res_last_q;
  logic [HashWidth-1:0]  res_src_q;
  logic [HashWidth-1:0]  res_out_q;
  logic [CountWidth-1:0] res_tally_q;

  logic [F32Width-1:0]   f32;
  logic [7:0]            out_byte;
  logic [7:0]            src_byte;
  logic [HashWidth-1:0]  src_fold;
  logic [HashWidth-1:0]  out_fold;
  logic [CountWidth-1:0] tally_inc;
  logic                  res_free;
  logic                  finish;
  logic                  src_ok;
  logic                  out_ok;
  logic                  cnt_ok;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_src_q  <= '0;
      exp_out_q  <= '0;
      exp_elem_q <= ExpElemWidth'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_EXP_SRC_HASH: exp_src_q  <= cfg_data_i;
        CFG_EXP_OUT_HASH: exp_out_q  <= cfg_data_i;
        CFG_EXP_ELEMENTS: exp_elem_q <= cfg_data_i[ExpElemWidth-1:0];
        default: ;
      endcase
    end
  end

  // Select this step's bytes and fold them
  assign f32       = {item_q.word, {(F32Width-WordWidth){1'b0}}};
  assign out_byte  = f32[{step_q, 3'b000} +: 8];
  assign src_byte  = item_q.word[{step_q[0], 3'b000} +: 8];
  assign src_fold  = fnv_fold(src_acc_q, src_byte);
  assign out_fold  = fnv_fold(out_acc_q, out_byte);
  assign tally_inc = (tally_q == {CountWidth{1'b1}}) ? tally_q : tally_q + 1'b1;

  assign res_free  = !res_valid_q || m_axis_tready_i;
  assign finish    = busy_q && (step_q == 2'd3) && res_free;
  assign q_pop_o   = q_valid_i && (!busy_q || finish);

  // Sequence the four byte steps of an item
  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    src_acc_d   = src_acc_q;
    out_acc_d   = out_acc_q;
    tally_d     = tally_q;
    res_valid_d = res_valid_q && !m_axis_tready_i;
    if (busy_q && step_q != 2'd3) begin
      out_acc_d = out_fold;
      if (!step_q[1]) begin
        src_acc_d = src_fold;
      end
      step_d = step_q + 1'b1;
    end
    if (finish) begin
      res_valid_d = 1'b1;
      busy_d      = 1'b0;
      step_d      = '0;
      if (item_q.last) begin
        src_acc_d = FnvBasis;
        out_acc_d = FnvBasis;
        tally_d   = '0;
      end else begin
        out_acc_d = out_fold;
        tally_d   = tally_inc;
      end
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      src_acc_q   <= FnvBasis;
      out_acc_q   <= FnvBasis;
      tally_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      src_acc_q   <= src_acc_d;
      out_acc_q   <= out_acc_d;
      tally_q     <= tally_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold the item and capture the result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (finish) begin
      res_word_q  <= item_q.word;
      res_last_q  <= item_q.last;
      res_src_q   <= src_acc_q;
      res_out_q   <= out_fold;
      res_tally_q <= tally_inc;
    end
  end

  // Match flags from held result; user must keep the configuration stable
  assign src_ok = res_last_q && (res_src_q == exp_src_q);
  assign out_ok = res_last_q && (res_out_q == exp_out_q);
  assign cnt_ok = res_last_q && (CmpWidth'(res_tally_q) == CmpWidth'(exp_elem_q));

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tlast_o  = res_last_q;
  assign m_axis_tdata_o  = {5'b0, cnt_ok, out_ok, src_ok, res_out_q, res_src_q,
                            res_word_q, {(F32Width-WordWidth){1'b0}}};

endmodule

### rtl/bf16_to_f32_checked_converter.sv
// An input is queued, then taken by the hash engine, which folds one byte per
// cycle into the output FNV-1a 64 hash (four bytes per F32 word) and registers
// the result once the output is free; it takes the next item as it finishes.
// A 2-entry input queue decouples input acceptance from the hash engine.
// Reset (rst_ni low, asynchronous): queue and result emptied, hashes at the
// FNV offset basis, element count zero, expected registers 0, 0 and 1.
// ----------------------------------------------------------------------------
// bf16_to_f32_checked_converter
// Widens BF16 words to F32 patterns and checks running FNV-1a 64 digests of
// the source and output bytes and the element count against expected values.
// ----------------------------------------------------------------------------
module bf16_to_f32_checked_converter import bfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [HashWidth-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [WordWidth-1:0] s_axis_tdata_i,   // [15:0] bf16_word
  input  logic                 s_axis_tlast_i,   // is_final
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [TdataOutW-1:0] m_axis_tdata_o,   // [31:0] f32_pattern,
                                                 // [95:32] source_digest,
                                                 // [159:96] output_digest,
                                                 // [160] source_ok,
                                                 // [161] output_ok,
                                                 // [162] count_ok, rest zero
  output logic                 m_axis_tlast_o    // end_of_slice
);

  logic      q_valid;
  bfc_item_t q_item;
  logic      q_pop;

  // Accept and queue input transfers
  bfc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  // Hash, count and produce results
  bfc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
